[sv/acrl_pkg.sv]
// ----------------------------------------------------------------------------
// acrl_pkg
// Shared types and constants for the adaptive client rate limiter.
// ----------------------------------------------------------------------------
package acrl_pkg;

  localparam int CLIENTS   = 16;
  localparam int SLOT_W    = 4;
  localparam int TIME_W    = 40;
  localparam int RATE_W    = 16;
  localparam int CNT_W     = 17;
  localparam int SAT_W     = 16;
  localparam int THR_W     = 8;
  localparam int MS_W      = 32;
  localparam int TOTAL_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;

  // Fixed length of the request counting window
  localparam logic [TIME_W-1:0] WINDOW_MS = TIME_W'(60000);

  // Item modes
  localparam logic [1:0] MODE_REQ     = 2'd0;
  localparam logic [1:0] MODE_AUTH    = 2'd1;
  localparam logic [1:0] MODE_UNBLOCK = 2'd2;
  localparam logic [1:0] MODE_QUERY   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RATE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTH_THR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_DUR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN  = 3'd4;

  typedef struct packed {
    logic [1:0]        mode;
    logic [SLOT_W-1:0] client_slot;
    logic [TIME_W-1:0] now_ms;
  } req_t;

  typedef struct packed {
    logic               allowed;
    logic               blocked;
    logic               lock_cause;
    logic [TIME_W-1:0]  lock_end;
    logic [RATE_W-1:0]  cur_limit;
    logic               unblock_done;
    logic [TOTAL_W-1:0] total_blocks;
    logic [TOTAL_W-1:0] total_denied;
  } res_t;

  typedef struct packed {
    logic              enabled;
    logic [RATE_W-1:0] rate_cap;
    logic [THR_W-1:0]  fail_limit;
    logic [MS_W-1:0]   lock_ms;
    logic [MS_W-1:0]   cooldown_ms;
  } cfg_t;

  // One client slot, minus its valid bit
  typedef struct packed {
    logic              blocked;
    logic [TIME_W-1:0] block_end;
    logic [CNT_W-1:0]  req_count;
    logic [RATE_W-1:0] limit;
    logic [SAT_W-1:0]  violations;
    logic [TIME_W-1:0] window_start;
    logic [TIME_W-1:0] cooldown_start;
    logic [SAT_W-1:0]  auth_fails;
  } slot_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic prep;
    logic upd;
    logic rpt;
  } cmd_t;

endpackage

[sv/acrl_ctrl.sv]
// ----------------------------------------------------------------------------
// acrl_ctrl
// Sequencer: load, prepare, update, report, one item at a time.
// ----------------------------------------------------------------------------
module acrl_ctrl
  import acrl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  output cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_RPT  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start) state_nxt = ST_PREP;
      ST_PREP: state_nxt = ST_UPD;
      ST_UPD:  state_nxt = ST_RPT;
      ST_RPT:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy     = (state_r != ST_IDLE);
  assign cmd.load = (state_r == ST_IDLE) && start;
  assign cmd.prep = (state_r == ST_PREP);
  assign cmd.upd  = (state_r == ST_UPD);
  assign cmd.rpt  = (state_r == ST_RPT);

endmodule

[sv/acrl_dp.sv]
// ----------------------------------------------------------------------------
// acrl_dp
// Slot table, per-item working record, global counters and result register.
// ----------------------------------------------------------------------------
module acrl_dp
  import acrl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  cmd_t cmd,
  input  cfg_t cfg,
  input  req_t in_data,
  output logic out_valid,
  output res_t out_data
);

  // Slot table: valid bits reset, payload only meaningful when valid
  logic [CLIENTS-1:0] slot_vld_r;
  slot_t              tab_r [CLIENTS];

  // Working copy of the item and its slot
  logic [1:0]        mode_r;
  logic [SLOT_W-1:0] slot_r;
  logic [TIME_W-1:0] now_r;
  logic              vld_r;
  slot_t             rec_r;

  // Prepared flags
  logic              blk_act_r;
  logic              cd_exp_r;
  logic              win_exp_r;
  logic [TIME_W-1:0] end_sat_r;
  logic [SAT_W-1:0]  auth_inc_r;
  logic              auth_hit_r;

  logic               allow_r;
  logic               undone_r;
  logic [TOTAL_W-1:0] blocks_r;
  logic [TOTAL_W-1:0] denied_r;
  logic               out_valid_r;
  res_t               out_data_r;

  // ---- load: read slot, apply first touch ----
  logic  tch;
  slot_t fresh;
  always_comb begin
    tch                  = cfg.enabled && (in_data.mode inside {MODE_REQ, MODE_AUTH});
    fresh                = '0;
    fresh.limit          = cfg.rate_cap;
    fresh.window_start   = in_data.now_ms;
  end

  // ---- prepare: time compares and saturating sums ----
  logic [TIME_W:0]   end_sum;
  logic [TIME_W-1:0] cd_diff;
  logic [TIME_W-1:0] win_diff;
  logic [SAT_W-1:0]  auth_inc;
  always_comb begin
    end_sum  = {1'b0, now_r} + {{(TIME_W+1-MS_W){1'b0}}, cfg.lock_ms};
    cd_diff  = now_r - rec_r.cooldown_start;
    win_diff = now_r - rec_r.window_start;
    auth_inc = (rec_r.auth_fails != '1) ? rec_r.auth_fails + 1'b1 : rec_r.auth_fails;
  end

  // ---- update: new slot record ----
  slot_t             nrec;
  logic [RATE_W-1:0] half;
  logic              allow_nxt;
  logic              undone_nxt;
  logic              deny;
  logic              blk_inc;
  logic              we;
  always_comb begin
    nrec       = rec_r;
    half       = '0;
    allow_nxt  = 1'b0;
    undone_nxt = 1'b0;
    deny       = 1'b0;
    blk_inc    = 1'b0;
    we         = 1'b0;
    case (mode_r)
      MODE_REQ: begin
        allow_nxt = 1'b1;
        if (cfg.enabled) begin
          we = 1'b1;
          if (blk_act_r) begin
            allow_nxt = 1'b0;
            deny      = 1'b1;
          end else begin
            nrec.blocked = 1'b0;
            if (cd_exp_r) begin
              nrec.limit          = cfg.rate_cap;
              nrec.violations     = '0;
              nrec.cooldown_start = '0;
              nrec.req_count      = '0;
            end
            if (win_exp_r) begin
              nrec.window_start = now_r;
              nrec.req_count    = '0;
            end
            if (nrec.req_count != '1) nrec.req_count = nrec.req_count + 1'b1;
            if (nrec.req_count > {1'b0, nrec.limit}) begin
              half = nrec.limit >> 1;
              if (nrec.violations == '0) nrec.cooldown_start = now_r;
              if (nrec.violations != '1) nrec.violations = nrec.violations + 1'b1;
              nrec.limit     = (half == '0) ? RATE_W'(1) : half;
              nrec.blocked   = 1'b1;
              nrec.block_end = end_sat_r;
              blk_inc        = 1'b1;
              deny           = 1'b1;
              allow_nxt      = 1'b0;
            end
          end
        end
      end
      MODE_AUTH: begin
        if (cfg.enabled) begin
          we              = 1'b1;
          nrec.auth_fails = auth_inc_r;
          if (auth_hit_r) begin
            nrec.blocked   = 1'b1;
            nrec.block_end = end_sat_r;
            blk_inc        = 1'b1;
          end
        end
      end
      MODE_UNBLOCK: begin
        if (vld_r && rec_r.blocked) begin
          we              = 1'b1;
          nrec.blocked    = 1'b0;
          nrec.block_end  = '0;
          nrec.auth_fails = '0;
          undone_nxt      = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ---- report ----
  res_t res;
  always_comb begin
    res               = '0;
    res.allowed       = allow_r;
    res.unblock_done  = undone_r;
    res.total_blocks  = blocks_r;
    res.total_denied  = denied_r;
    res.cur_limit     = vld_r ? rec_r.limit : cfg.rate_cap;
    if (cfg.enabled && vld_r && rec_r.blocked && (now_r < rec_r.block_end)) begin
      res.blocked    = 1'b1;
      res.lock_end   = rec_r.block_end;
      res.lock_cause = (rec_r.auth_fails >= {{(SAT_W-THR_W){1'b0}}, cfg.fail_limit});
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r  <= '0;
      blocks_r    <= '0;
      denied_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.rpt;
      if (cmd.upd) begin
        if (we) slot_vld_r[slot_r] <= 1'b1;
        if (blk_inc) blocks_r <= blocks_r + 1'b1;
        if (deny) denied_r <= denied_r + 1'b1;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_data.mode;
      slot_r <= in_data.client_slot;
      now_r  <= in_data.now_ms;
      if (tch && !slot_vld_r[in_data.client_slot]) begin
        vld_r <= 1'b1;
        rec_r <= fresh;
      end else begin
        vld_r <= slot_vld_r[in_data.client_slot];
        rec_r <= tab_r[in_data.client_slot];
      end
    end
    if (cmd.prep) begin
      blk_act_r  <= rec_r.blocked && (now_r < rec_r.block_end);
      cd_exp_r   <= (rec_r.violations != '0) &&
                    (cd_diff >= {{(TIME_W-MS_W){1'b0}}, cfg.cooldown_ms});
      win_exp_r  <= (win_diff >= WINDOW_MS);
      end_sat_r  <= end_sum[TIME_W] ? '1 : end_sum[TIME_W-1:0];
      auth_inc_r <= auth_inc;
      auth_hit_r <= (auth_inc >= {{(SAT_W-THR_W){1'b0}}, cfg.fail_limit});
    end
    if (cmd.upd) begin
      rec_r    <= nrec;
      allow_r  <= allow_nxt;
      undone_r <= undone_nxt;
      if (we) tab_r[slot_r] <= nrec;
    end
    if (cmd.rpt) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sv/adaptive_client_rate_limiter_core.sv]
// ----------------------------------------------------------------------------
// adaptive_client_rate_limiter_core
// Per-client fixed-window rate limiter with adaptive limit and lockout.
// ----------------------------------------------------------------------------
// The result strobe (out_valid) is registered from the report state, so it is
// high as the sequencer returns to idle.
// Items are taken one at a time through the load/prepare/update/report
// sequence around the single slot read-modify-write; busy holds off a new one.
// Reset (rst_n low, synchronous): all slots invalid, totals zero, registers
// back to defaults; no clearing pass. The receiver cannot stall out_valid.
// ----------------------------------------------------------------------------
module adaptive_client_rate_limiter_core
  import acrl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // item input
  input  logic                 start,
  output logic                 busy,
  input  req_t                 in_data,
  // results
  output logic                 out_valid,
  output res_t                 out_data,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  cfg_t cfg_r;
  cmd_t cmd;

  // Registers change only between items: not while one is in flight and not
  // at the edge that takes a new one.
  assign cfg_ready = !busy && !start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled     <= 1'b1;
      cfg_r.rate_cap    <= RATE_W'(60);
      cfg_r.fail_limit  <= THR_W'(5);
      cfg_r.lock_ms     <= MS_W'(600000);
      cfg_r.cooldown_ms <= MS_W'(300000);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ENABLED:   cfg_r.enabled     <= cfg_data[0];
        CFG_MAX_RATE:  cfg_r.rate_cap    <= cfg_data[RATE_W-1:0];
        CFG_AUTH_THR:  cfg_r.fail_limit  <= cfg_data[THR_W-1:0];
        CFG_BLOCK_DUR: cfg_r.lock_ms     <= cfg_data[MS_W-1:0];
        CFG_COOLDOWN:  cfg_r.cooldown_ms <= cfg_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  acrl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Slot table and arithmetic
  acrl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg       (cfg_r),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Accepted item keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not make block busy");

  // Every finished item is reported as busy drops
  a_done_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("item finished without result strobe");

  // One strobe per item, never in back-to-back cycles
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  // Results appear only when the sequencer is back to idle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

endmodule
